// ----- hw/rtl/wdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdq_pkg
// Shared types, codes and constants of the weight dequantizer.
// ----------------------------------------------------------------------------
package wdq_pkg;

  // Weight encodings held in the format register
  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S8  = 3'd1,
    FMT_U4  = 3'd2,
    FMT_S4  = 3'd3,
    FMT_NF4 = 3'd4
  } weight_fmt_t;

  // Configuration register indexes
  localparam logic [2:0] REG_WEIGHT_FORMAT      = 3'd0;
  localparam logic [2:0] REG_OUTPUT_BF16        = 3'd1;
  localparam logic [2:0] REG_APPLY_SCALE        = 3'd2;
  localparam logic [2:0] REG_APPLY_ZERO_POINT   = 3'd3;
  localparam logic [2:0] REG_ZERO_POINT_IS_BYTE = 3'd4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 3;

  // Pipeline depth from input register to output register
  localparam int unsigned NUM_STAGES = 8;

  // IEEE single special encodings
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

  // NF4 code points as IEEE single bits
  localparam logic [31:0] NF4_TABLE [16] = '{
    32'hBF80_0000, 32'hBF32_39B1, 32'hBF06_6B30, 32'hBECA_32A0,
    32'hBE91_A24D, 32'hBE3D_353F, 32'hBDBA_7871, 32'h0000_0000,
    32'h3DA2_FAFF, 32'h3E24_CAE3, 32'h3E7C_04DD, 32'h3EAD_033A,
    32'h3EE1_A4B8, 32'h3F10_07AB, 32'h3F39_13B3, 32'h3F80_0000
  };

endpackage

// ----- hw/rtl/weight_dequantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_dequantizer
// Decodes one packed weight code per transfer, optionally subtracts a zero point,
// optionally multiplies by a scale and returns f32 or bf16 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with packed_byte, upper_nibble,
//   zero_point and scale. Output channel: out_valid / out_stall with
//   weight_value. A transfer happens when valid is high and stall is low.
//   Configuration: write cfg_write with cfg_index / cfg_data while idle.
// Stages: decode, three subtract stages, three multiply stages and an
//   output format stage.
// Throughput: one item per cycle while out_stall holds no result; every
//   stage is registered and the multiplier is a single 24x24 product stage.
// Reset: rst clears all stage valids and the configuration registers.
// Stall: while out_stall holds a valid result, the whole pipeline freezes
//   and in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module weight_dequantizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [wdq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wdq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  packed_byte,
  input  logic        upper_nibble,
  input  logic [31:0] zero_point,
  input  logic [31:0] scale,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] weight_value
);

  // Configuration registers
  wdq_pkg::weight_fmt_t weight_format;
  logic output_bf16;
  logic apply_scale;
  logic apply_zero_point;
  logic zero_point_is_byte;

  logic [wdq_pkg::NUM_STAGES-1:0] vld;
  logic en;

  // ------------------------------------------------------------------
  // Helpers
  // ------------------------------------------------------------------
  function automatic logic [31:0] int_to_f32(input logic sgn, input logic [7:0] mag);
    logic [2:0]  p;
    logic [23:0] m24;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag[i]) p = 3'(i);
    end
    m24 = {16'd0, mag} << (5'd23 - {2'd0, p});
    if (mag == 8'd0) return 32'd0;
    return {sgn, 8'd127 + {5'd0, p}, m24[22:0]};
  endfunction

  function automatic logic is_nan(input logic [31:0] u);
    return (u[30:23] == 8'hFF) && (u[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] u);
    return (u[30:23] == 8'hFF) && (u[22:0] == 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] u);
    return u[30:0] == 31'd0;
  endfunction

  // ------------------------------------------------------------------
  // Configuration writes
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_format      <= wdq_pkg::FMT_U8;
      output_bf16        <= 1'b0;
      apply_scale        <= 1'b0;
      apply_zero_point   <= 1'b0;
      zero_point_is_byte <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wdq_pkg::REG_WEIGHT_FORMAT:      weight_format <= wdq_pkg::weight_fmt_t'(cfg_data);
        wdq_pkg::REG_OUTPUT_BF16:        output_bf16 <= cfg_data[0];
        wdq_pkg::REG_APPLY_SCALE:        apply_scale <= cfg_data[0];
        wdq_pkg::REG_APPLY_ZERO_POINT:   apply_zero_point <= cfg_data[0];
        wdq_pkg::REG_ZERO_POINT_IS_BYTE: zero_point_is_byte <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Freeze every stage while a finished result is held back
  assign en       = !(vld[wdq_pkg::NUM_STAGES-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[wdq_pkg::NUM_STAGES-2:0], in_valid};
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: decode weight and zero point
  // ------------------------------------------------------------------
  logic [31:0] s1_w, s1_zp, s1_sc;
  logic [31:0] dec_w, dec_zp;
  logic [3:0]  nib;

  always_comb begin
    nib = upper_nibble ? packed_byte[7:4] : packed_byte[3:0];
    unique case (weight_format)
      wdq_pkg::FMT_S8:
        dec_w = int_to_f32(packed_byte[7], packed_byte[7] ? 8'(-packed_byte) : packed_byte);
      wdq_pkg::FMT_U4:
        dec_w = int_to_f32(1'b0, {4'd0, nib});
      wdq_pkg::FMT_S4:
        dec_w = int_to_f32(nib[3], {4'd0, nib[3] ? 4'(-nib) : nib});
      wdq_pkg::FMT_NF4:
        dec_w = wdq_pkg::NF4_TABLE[nib];
      default:
        dec_w = int_to_f32(1'b0, packed_byte);
    endcase
    dec_zp = zero_point_is_byte ? int_to_f32(1'b0, zero_point[7:0]) : zero_point;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w  <= dec_w;
      s1_zp <= dec_zp;
      s1_sc <= scale;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: subtract, specials and operand swap
  // ------------------------------------------------------------------
  logic [31:0] s2_w, s2_sc, s2_spec_val;
  logic        s2_spec, s2_sign, s2_zsign, s2_eff_sub;
  logic [7:0]  s2_exp, s2_d;
  logic [23:0] s2_big_man, s2_small_man;

  logic [31:0] a2, bn2, big2, sml2, spec_val2;
  logic        spec2;
  logic [7:0]  eb2, es2;

  always_comb begin
    a2   = s1_w;
    bn2  = {~s1_zp[31], s1_zp[30:0]};
    spec2 = 1'b1;
    spec_val2 = 32'd0;
    priority if (is_nan(a2)) begin
      spec_val2 = a2 | wdq_pkg::QUIET_BIT;
    end else if (is_nan(s1_zp)) begin
      spec_val2 = s1_zp | wdq_pkg::QUIET_BIT;
    end else if (is_inf(a2) && is_inf(s1_zp) && (a2[31] == s1_zp[31])) begin
      spec_val2 = wdq_pkg::DEFAULT_NAN;
    end else if (is_inf(a2)) begin
      spec_val2 = a2;
    end else if (is_inf(s1_zp)) begin
      spec_val2 = bn2;
    end else begin
      spec2 = 1'b0;
    end
    if (a2[30:0] >= bn2[30:0]) begin
      big2 = a2;
      sml2 = bn2;
    end else begin
      big2 = bn2;
      sml2 = a2;
    end
    eb2 = (big2[30:23] == 8'd0) ? 8'd1 : big2[30:23];
    es2 = (sml2[30:23] == 8'd0) ? 8'd1 : sml2[30:23];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_w         <= s1_w;
      s2_sc        <= s1_sc;
      s2_spec      <= spec2;
      s2_spec_val  <= spec_val2;
      s2_sign      <= big2[31];
      s2_zsign     <= a2[31] & bn2[31];
      s2_eff_sub   <= big2[31] ^ sml2[31];
      s2_exp       <= eb2;
      s2_d         <= eb2 - es2;
      s2_big_man   <= {big2[30:23] != 8'd0, big2[22:0]};
      s2_small_man <= {sml2[30:23] != 8'd0, sml2[22:0]};
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: align the smaller operand and add
  // ------------------------------------------------------------------
  logic [31:0] s3_w, s3_sc, s3_spec_val;
  logic        s3_spec, s3_sign, s3_zsign;
  logic [7:0]  s3_exp;
  logic [27:0] s3_sum;

  logic [53:0] sh3;
  logic [26:0] mb3, ma3;
  logic [27:0] sum3;

  always_comb begin
    ma3 = {s2_big_man, 3'b000};
    sh3 = {s2_small_man, 30'd0} >> s2_d[4:0];
    if (s2_d >= 8'd27) begin
      mb3 = {26'd0, |s2_small_man};
    end else begin
      mb3 = {sh3[53:28], |sh3[27:0]};
    end
    sum3 = s2_eff_sub ? ({1'b0, ma3} - {1'b0, mb3}) : ({1'b0, ma3} + {1'b0, mb3});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_w        <= s2_w;
      s3_sc       <= s2_sc;
      s3_spec     <= s2_spec;
      s3_spec_val <= s2_spec_val;
      s3_sign     <= s2_sign;
      s3_zsign    <= s2_zsign;
      s3_exp      <= s2_exp;
      s3_sum      <= sum3;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: normalize and round the difference
  // ------------------------------------------------------------------
  logic [31:0] s4_w, s4_sc;

  logic [4:0]  lz4, sh4;
  logic [7:0]  lim4;
  logic [8:0]  e4;
  logic [26:0] n4;
  logic [7:0]  ef4;
  logic        rnd4;
  logic [30:0] pk4;
  logic [31:0] r4;

  always_comb begin
    lz4 = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (s3_sum[i]) lz4 = 5'(26 - i);
    end
    lim4 = s3_exp - 8'd1;
    sh4  = ({3'd0, lz4} < lim4) ? lz4 : lim4[4:0];
    if (s3_sum[27]) begin
      n4 = {s3_sum[27:2], s3_sum[1] | s3_sum[0]};
      e4 = {1'b0, s3_exp} + 9'd1;
    end else begin
      n4 = s3_sum[26:0] << sh4;
      e4 = {1'b0, s3_exp} - {4'd0, sh4};
    end
    ef4  = n4[26] ? e4[7:0] : 8'd0;
    rnd4 = n4[2] & (n4[1] | n4[0] | n4[3]);
    pk4  = {ef4, n4[25:3]} + {30'd0, rnd4};
    priority if (s3_spec) begin
      r4 = s3_spec_val;
    end else if (s3_sum == 28'd0) begin
      r4 = {s3_zsign, 31'd0};
    end else if (e4 >= 9'd255) begin
      r4 = {s3_sign, 8'hFF, 23'd0};
    end else begin
      r4 = {s3_sign, pk4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_w  <= apply_zero_point ? r4 : s3_w;
      s4_sc <= s3_sc;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: multiply mantissas, resolve specials
  // ------------------------------------------------------------------
  logic [31:0] s5_w, s5_spec_val;
  logic        s5_spec, s5_sign;
  logic signed [10:0] s5_e;
  logic [47:0] s5_prod;

  logic [31:0] spec_val5;
  logic        spec5;
  logic [7:0]  ea5, eb5;

  always_comb begin
    spec5 = 1'b1;
    spec_val5 = 32'd0;
    priority if (is_nan(s4_w)) begin
      spec_val5 = s4_w | wdq_pkg::QUIET_BIT;
    end else if (is_nan(s4_sc)) begin
      spec_val5 = s4_sc | wdq_pkg::QUIET_BIT;
    end else if ((is_inf(s4_w) && is_zero(s4_sc)) || (is_zero(s4_w) && is_inf(s4_sc))) begin
      spec_val5 = wdq_pkg::DEFAULT_NAN;
    end else if (is_inf(s4_w) || is_inf(s4_sc)) begin
      spec_val5 = {s4_w[31] ^ s4_sc[31], 8'hFF, 23'd0};
    end else if (is_zero(s4_w) || is_zero(s4_sc)) begin
      spec_val5 = {s4_w[31] ^ s4_sc[31], 31'd0};
    end else begin
      spec5 = 1'b0;
    end
    ea5 = (s4_w[30:23] == 8'd0) ? 8'd1 : s4_w[30:23];
    eb5 = (s4_sc[30:23] == 8'd0) ? 8'd1 : s4_sc[30:23];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_w        <= s4_w;
      s5_spec     <= spec5;
      s5_spec_val <= spec_val5;
      s5_sign     <= s4_w[31] ^ s4_sc[31];
      s5_e        <= $signed({3'd0, ea5}) + $signed({3'd0, eb5}) - 11'sd126;
      s5_prod     <= {s4_w[30:23] != 8'd0, s4_w[22:0]} *
                     {s4_sc[30:23] != 8'd0, s4_sc[22:0]};
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: normalize the product
  // ------------------------------------------------------------------
  logic [31:0] s6_w, s6_spec_val;
  logic        s6_spec, s6_sign;
  logic signed [10:0] s6_e;
  logic [47:0] s6_norm;

  logic [5:0] lz6;

  always_comb begin
    lz6 = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (s5_prod[i]) lz6 = 6'(47 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_w        <= s5_w;
      s6_spec     <= s5_spec;
      s6_spec_val <= s5_spec_val;
      s6_sign     <= s5_sign;
      s6_e        <= s5_e - $signed({5'd0, lz6});
      s6_norm     <= s5_prod << lz6;
    end
  end

  // ------------------------------------------------------------------
  // Stage 7: round the product, denormalize when tiny
  // ------------------------------------------------------------------
  logic [31:0] s7_w;

  logic signed [10:0] rs7_full;
  logic [5:0]  rs7;
  logic [95:0] dn7;
  logic [47:0] m7;
  logic        st7, rnd7;
  logic [30:0] pk7;
  logic [31:0] r7;

  always_comb begin
    rs7_full = 11'sd1 - s6_e;
    rs7 = (rs7_full > 11'sd48) ? 6'd48 : rs7_full[5:0];
    dn7 = {s6_norm, 48'd0} >> rs7;
    if (s6_e >= 11'sd1) begin
      m7  = {1'b0, s6_norm[47:1]};
      st7 = |s6_norm[22:0];
      rnd7 = s6_norm[23] & (st7 | s6_norm[24]);
      pk7 = {s6_e[7:0], s6_norm[46:24]} + {30'd0, rnd7};
    end else begin
      m7  = dn7[95:48];
      st7 = (|dn7[47:0]) | (|m7[22:0]);
      rnd7 = m7[23] & (st7 | m7[24]);
      pk7 = {8'd0, m7[46:24]} + {30'd0, rnd7};
    end
    priority if (s6_spec) begin
      r7 = s6_spec_val;
    end else if (s6_e >= 11'sd255) begin
      r7 = {s6_sign, 8'hFF, 23'd0};
    end else begin
      r7 = {s6_sign, pk7};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_w <= apply_scale ? r7 : s6_w;
    end
  end

  // ------------------------------------------------------------------
  // Stage 8: output format
  // ------------------------------------------------------------------
  logic [31:0] rnd8;
  logic [31:0] bf8;

  always_comb begin
    rnd8 = s7_w + 32'h0000_7FFF + {31'd0, s7_w[16]};
    priority if (is_nan(s7_w)) begin
      bf8 = {16'd0, s7_w[31:16] | 16'h0040};
    end else if (s7_w[30:23] == 8'd0) begin
      bf8 = {16'd0, s7_w[31], 15'd0};
    end else begin
      bf8 = {16'd0, rnd8[31:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight_value <= output_bf16 ? bf8 : s7_w;
    end
  end

  assign out_valid = vld[wdq_pkg::NUM_STAGES-1];

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted transfer did not enter the pipeline");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld))
    else $error("pipeline valids moved during stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_bf16: assert property (@(posedge clk) disable iff (rst)
    out_valid && output_bf16 |-> weight_value[31:16] == 16'd0)
    else $error("bf16 result has upper bits set");

endmodule
